// ===== rtl/twm_pkg.sv =====
// ----------------------------------------------------------------------------
// twm_pkg
// Types, operation codes and status codes shared by the word machine core.
// ----------------------------------------------------------------------------
`default_nettype none

package twm_pkg;

  localparam int unsigned WORDS_PER_BLOCK = 16;

  // Item kinds.
  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_STEP  = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;

  // Result status codes.
  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_NOT_RUNNING = 3'd1;
  localparam logic [2:0] STAT_UNKNOWN     = 3'd2;
  localparam logic [2:0] STAT_DIV_ZERO    = 3'd3;
  localparam logic [2:0] STAT_IO_SKIPPED  = 3'd4;

  // Compare flag codes.
  localparam logic [1:0] FLAG_EQUAL   = 2'd0;
  localparam logic [1:0] FLAG_GREATER = 2'd1;
  localparam logic [1:0] FLAG_LESS    = 2'd2;

  // Operation codes: first byte * 16 + second byte.
  localparam logic [12:0] OP_WA = 13'h05B1;
  localparam logic [12:0] OP_WB = 13'h05B2;
  localparam logic [12:0] OP_LA = 13'h0501;
  localparam logic [12:0] OP_LB = 13'h0502;
  localparam logic [12:0] OP_AD = 13'h0454;
  localparam logic [12:0] OP_SU = 13'h0585;
  localparam logic [12:0] OP_MU = 13'h0525;
  localparam logic [12:0] OP_DI = 13'h0489;
  localparam logic [12:0] OP_CM = 13'h047D;
  localparam logic [12:0] OP_JP = 13'h04F0;
  localparam logic [12:0] OP_JE = 13'h04E5;
  localparam logic [12:0] OP_JN = 13'h04EE;
  localparam logic [12:0] OP_JG = 13'h04E7;
  localparam logic [12:0] OP_IN = 13'h04DE;
  localparam logic [12:0] OP_OT = 13'h0544;
  localparam logic [12:0] OP_HA = 13'h04C1;
  localparam logic [12:0] OP_BI = 13'h0469;
  localparam logic [12:0] OP_BO = 13'h046F;
  localparam logic [12:0] OP_FO = 13'h04AF;
  localparam logic [12:0] OP_FC = 13'h04A3;
  localparam logic [12:0] OP_FD = 13'h04A4;
  localparam logic [12:0] OP_WF = 13'h05B6;
  localparam logic [12:0] OP_BW = 13'h0477;
  localparam logic [12:0] OP_RF = 13'h0566;
  localparam logic [12:0] OP_BR = 13'h0472;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         load_address;
    logic [31:0]        load_data;
    logic signed [31:0] console_value;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               print_valid;
    logic signed [31:0] print_value;
    logic [7:0]         next_counter;
    logic signed [31:0] reg_a_value;
    logic signed [31:0] reg_b_value;
    logic [1:0]         compare_flag;
    logic               running_flag;
  } res_word_t;

  // Reduces an 8-bit address modulo the store size (at least 16 words, so the
  // quotient fits in four bits and four compare-subtract steps suffice).
  function automatic logic [7:0] store_index(input logic [7:0] addr,
                                             input logic [8:0] size);
    logic [12:0] rem;
    logic [12:0] part;
    rem = {5'd0, addr};
    for (int k = 3; k >= 0; k--) begin
      part = {4'd0, size} << k;
      if (rem >= part) begin
        rem = rem - part;
      end
    end
    return rem[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/twm_cmd_if.sv =====
// ----------------------------------------------------------------------------
// twm_cmd_if
// Valid/ready channel that carries command words into the core.
// ----------------------------------------------------------------------------
`default_nettype none

interface twm_cmd_if
  import twm_pkg::*;
  ;
  logic      valid;
  logic      ready;
  cmd_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/twm_res_if.sv =====
// ----------------------------------------------------------------------------
// twm_res_if
// Valid/ready channel that carries result words out of the core.
// ----------------------------------------------------------------------------
`default_nettype none

interface twm_res_if
  import twm_pkg::*;
  ;
  logic      valid;
  logic      ready;
  res_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/two_register_word_machine_core.sv =====
// ----------------------------------------------------------------------------
// two_register_word_machine_core
// Accumulator machine with registers A and B, a compare flag and a word store.
// ----------------------------------------------------------------------------
// Command words arrive on cmd: a load word writes the store, a start word
// clears the counter and sets the machine running, and a step word fetches
// and executes the instruction at the counter. Every command word yields
// exactly one result word on res with the status and the machine state.
// A load, a start or a step while halted goes from the idle state straight
// to the done state. A step while running passes fetch, decode and execute;
// loads and output add a load state, and a divide by a nonzero B waits in a
// divide state for the divider, which produces one quotient bit per cycle.
// The result word becomes valid in the cycle in which cmd.ready returns.
// cmd.ready is high only while the sequencer waits for a word;
// the result sits in an output register, so the next command is taken while
// a result is still unclaimed, but its own result waits until res is free.
// Reset clears A, B, the counter, the flag and the running bit; the store is
// not cleared and must be loaded before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module two_register_word_machine_core
  import twm_pkg::*;
#(
  parameter int unsigned BLOCK_COUNT = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  twm_cmd_if.sink    cmd,
  twm_res_if.source  res
);

  localparam int unsigned STORE_SIZE = BLOCK_COUNT * WORDS_PER_BLOCK;
  localparam int unsigned AW         = $clog2(STORE_SIZE);
  localparam logic [8:0]  SIZE9      = 9'(STORE_SIZE);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FETCH  = 3'd1;
  localparam logic [2:0] S_DECODE = 3'd2;
  localparam logic [2:0] S_EXEC   = 3'd3;
  localparam logic [2:0] S_LOAD   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]  state;
  logic [31:0] reg_a;
  logic [31:0] reg_b;
  logic [7:0]  counter;
  logic [1:0]  flag;
  logic        running;
  logic [2:0]  status;
  logic        print_valid;
  logic [31:0] print_value;
  logic [31:0] console;
  logic [12:0] op;
  logic [7:0]  target;
  logic [AW-1:0] op_addr;

  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [31:0]   mem_wdata;
  logic [31:0]   mem_rdata;
  logic          div_start;
  logic          div_done;
  logic [31:0]   div_quot;
  logic          is_sub;
  logic [31:0]   alu_sum;
  logic [7:0]    fetch_target;
  logic [7:0]    load_index;
  logic [7:0]    pc_index;
  logic [7:0]    target_index;
  logic          cmd_fire;
  logic          res_load;

  assign cmd.ready = (state == S_IDLE) && !rst;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign res_load  = (state == S_DONE) && (!res.valid || res.ready);

  twm_store #(.DEPTH(STORE_SIZE)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  twm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (reg_a),
    .divisor  (reg_b),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Shared adder for add and subtract.
  assign is_sub  = (op == OP_SU);
  assign alu_sum = reg_a + (is_sub ? ~reg_b : reg_b) + {31'd0, is_sub};

  assign fetch_target = {mem_rdata[11:8], 4'd0} + mem_rdata[7:0];

  assign load_index   = store_index(cmd.data.load_address, SIZE9);
  assign pc_index     = store_index(counter, SIZE9);
  assign target_index = store_index(fetch_target, SIZE9);

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = op_addr;
    mem_wdata = reg_a;
    div_start = 1'b0;
    unique case (state)
      S_IDLE: begin
        mem_addr  = load_index[AW-1:0];
        mem_wdata = cmd.data.load_data;
        mem_we    = cmd_fire && (cmd.data.kind == KIND_LOAD);
      end
      S_FETCH: begin
        mem_addr = pc_index[AW-1:0];
      end
      S_EXEC: begin
        case (op)
          OP_WA: mem_we = 1'b1;
          OP_WB: begin
            mem_we    = 1'b1;
            mem_wdata = reg_b;
          end
          OP_IN: begin
            mem_we    = 1'b1;
            mem_wdata = console;
          end
          OP_DI: div_start = (reg_b != 32'd0);
          default: mem_we = 1'b0;
        endcase
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      reg_a     <= 32'd0;
      reg_b     <= 32'd0;
      counter   <= 8'd0;
      flag      <= FLAG_EQUAL;
      running   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            status      <= STAT_OK;
            print_valid <= 1'b0;
            print_value <= 32'd0;
            console     <= cmd.data.console_value;
            state       <= S_DONE;
            if (cmd.data.kind == KIND_START) begin
              counter <= 8'd0;
              running <= 1'b1;
            end else if (cmd.data.kind == KIND_STEP) begin
              if (running) begin
                state <= S_FETCH;
              end else begin
                status <= STAT_NOT_RUNNING;
              end
            end
          end
        end
        S_FETCH: state <= S_DECODE;
        S_DECODE: begin
          op      <= {5'd0, mem_rdata[31:24]} * 13'd16 + {5'd0, mem_rdata[23:16]};
          target  <= fetch_target;
          op_addr <= target_index[AW-1:0];
          state   <= S_EXEC;
        end
        S_EXEC: begin
          state   <= S_DONE;
          counter <= counter + 8'd1;
          case (op)
            OP_WA, OP_WB, OP_IN, OP_HA: begin
              if (op == OP_HA) begin
                running <= 1'b0;
              end
            end
            OP_LA, OP_LB, OP_OT: begin
              counter <= counter;
              state   <= S_LOAD;
            end
            OP_AD, OP_SU: reg_a <= alu_sum;
            OP_MU: reg_a <= reg_a * reg_b;
            OP_DI: begin
              counter <= counter;
              if (reg_b == 32'd0) begin
                running <= 1'b0;
                status  <= STAT_DIV_ZERO;
              end else begin
                state <= S_DIV;
              end
            end
            OP_CM: begin
              if (reg_a == reg_b) begin
                flag <= FLAG_EQUAL;
              end else if ($signed(reg_a) > $signed(reg_b)) begin
                flag <= FLAG_GREATER;
              end else begin
                flag <= FLAG_LESS;
              end
            end
            OP_JP: counter <= target;
            OP_JE: if (flag == FLAG_EQUAL) counter <= target;
            OP_JN: if (flag != FLAG_EQUAL) counter <= target;
            OP_JG: if (flag == FLAG_GREATER) counter <= target;
            OP_BI, OP_BO, OP_FO, OP_FC, OP_FD, OP_WF, OP_BW, OP_RF, OP_BR: begin
              status <= STAT_IO_SKIPPED;
            end
            default: begin
              counter <= counter;
              running <= 1'b0;
              status  <= STAT_UNKNOWN;
            end
          endcase
        end
        S_LOAD: begin
          counter <= counter + 8'd1;
          state   <= S_DONE;
          if (op == OP_LA) begin
            reg_a <= mem_rdata;
          end else if (op == OP_LB) begin
            reg_b <= mem_rdata;
          end else begin
            print_valid <= 1'b1;
            print_value <= mem_rdata;
          end
        end
        S_DIV: begin
          if (div_done) begin
            reg_a   <= div_quot;
            counter <= counter + 8'd1;
            state   <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The output register fills from the sequencer and empties when res takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (res_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // Result payload is captured when the word is handed to the output register.
  always_ff @(posedge clk) begin
    if (res_load) begin
      res.data.status       <= status;
      res.data.print_valid  <= print_valid;
      res.data.print_value  <= print_value;
      res.data.next_counter <= counter;
      res.data.reg_a_value  <= reg_a;
      res.data.reg_b_value  <= reg_b;
      res.data.compare_flag <= flag;
      res.data.running_flag <= running;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/twm_store.sv =====
// ----------------------------------------------------------------------------
// twm_store
// Single-port word store with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module twm_store #(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [31:0]              wdata,
  output logic [31:0]                   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== rtl/twm_div.sv =====
// ----------------------------------------------------------------------------
// twm_div
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module twm_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);

  logic        busy;
  logic        finish;
  logic [4:0]  count;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem, quo[31]};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      finish <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= 1'b0;
      finish <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 5'd0;
        rem   <= 32'd0;
        quo   <= dividend[31] ? (32'd0 - dividend) : dividend;
        dvs   <= divisor[31] ? (32'd0 - divisor) : divisor;
        neg   <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        rem   <= diff[32] ? shifted[31:0] : diff[31:0];
        quo   <= {quo[30:0], ~diff[32]};
        count <= count + 5'd1;
        if (count == 5'd31) begin
          busy   <= 1'b0;
          finish <= 1'b1;
        end
      end else if (finish) begin
        quotient <= neg ? (32'd0 - quo) : quo;
        done     <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking testbench for the two-register word machine core.
// ----------------------------------------------------------------------------
// Command words are generated together with the machine state they produce,
// using an in-bench behavioral machine. A driver offers the words in bursts
// with random gaps, and a monitor compares every result word field by field
// against the oldest outstanding prediction while the result side stalls on
// its own pattern, including one long hold-off that backs up the core.
// ----------------------------------------------------------------------------
module testbench;
  import twm_pkg::*;

  localparam logic [15:0] MNEMONICS [25] = '{
    "WA", "WB", "LA", "LB", "AD", "SU", "MU", "DI", "CM", "JP", "JE", "JN", "JG",
    "IN", "OT", "HA", "BI", "BO", "FO", "FC", "FD", "WF", "BW", "RF", "BR"};
  localparam int TARGET_WORDS = 1250;

  logic clk;
  logic rst;

  twm_cmd_if cmd_ch ();
  twm_res_if res_ch ();

  two_register_word_machine_core u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  // Behavioral copy of the machine, advanced as words are generated.
  logic [31:0] mach_a;
  logic [31:0] mach_b;
  logic [7:0]  mach_pc;
  logic [1:0]  mach_flag;
  logic        mach_run;
  logic [31:0] mach_mem [256];

  cmd_word_t pending_words [$];
  res_word_t pending_results [$];
  res_word_t expected_results [$];
  int        words_queued;
  int        words_accepted;
  int        error_count;
  bit        stimulus_done;

  int burst_left;
  int gap_left;
  int hold_left;
  bit hold_done;
  int ready_mode;
  int mode_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] signed_quotient(logic [31:0] num, logic [31:0] den);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] q;
    mag_n = num[31] ? -num : num;
    mag_d = den[31] ? -den : den;
    q = mag_n / mag_d;
    return (num[31] != den[31]) ? -q : q;
  endfunction

  function automatic res_word_t machine_step(cmd_word_t w);
    res_word_t   r;
    logic [31:0] instr;
    logic [12:0] op;
    logic [7:0]  addr;
    bit          jump;
    bit          advance;
    r = '0;
    r.status = STAT_OK;
    if (w.kind == KIND_LOAD) begin
      mach_mem[w.load_address] = w.load_data;
    end else if (w.kind == KIND_START) begin
      mach_pc = '0;
      mach_run = 1'b1;
    end else if (w.kind == KIND_STEP) begin
      if (!mach_run) begin
        r.status = STAT_NOT_RUNNING;
      end else begin
        instr = mach_mem[mach_pc];
        op = {5'd0, instr[31:24]} * 13'd16 + {5'd0, instr[23:16]};
        addr = instr[15:8] * 8'd16 + instr[7:0];
        jump = 1'b0;
        advance = 1'b1;
        case (op)
          OP_WA: mach_mem[addr] = mach_a;
          OP_WB: mach_mem[addr] = mach_b;
          OP_LA: mach_a = mach_mem[addr];
          OP_LB: mach_b = mach_mem[addr];
          OP_AD: mach_a = mach_a + mach_b;
          OP_SU: mach_a = mach_a - mach_b;
          OP_MU: mach_a = mach_a * mach_b;
          OP_DI: begin
            if (mach_b == '0) begin
              mach_run = 1'b0;
              advance = 1'b0;
              r.status = STAT_DIV_ZERO;
            end else begin
              mach_a = signed_quotient(mach_a, mach_b);
            end
          end
          OP_CM: begin
            if (mach_a == mach_b) mach_flag = FLAG_EQUAL;
            else if ($signed(mach_a) > $signed(mach_b)) mach_flag = FLAG_GREATER;
            else mach_flag = FLAG_LESS;
          end
          OP_JP: jump = 1'b1;
          OP_JE: jump = (mach_flag == FLAG_EQUAL);
          OP_JN: jump = (mach_flag != FLAG_EQUAL);
          OP_JG: jump = (mach_flag == FLAG_GREATER);
          OP_IN: mach_mem[addr] = w.console_value;
          OP_OT: begin
            r.print_valid = 1'b1;
            r.print_value = mach_mem[addr];
          end
          OP_BI, OP_BO, OP_FO, OP_FC, OP_FD, OP_WF, OP_BW, OP_RF, OP_BR:
            r.status = STAT_IO_SKIPPED;
          OP_HA: mach_run = 1'b0;
          default: begin
            mach_run = 1'b0;
            advance = 1'b0;
            r.status = STAT_UNKNOWN;
          end
        endcase
        if (jump) mach_pc = addr;
        else if (advance) mach_pc = mach_pc + 8'd1;
      end
    end
    r.next_counter = mach_pc;
    r.reg_a_value = mach_a;
    r.reg_b_value = mach_b;
    r.compare_flag = mach_flag;
    r.running_flag = mach_run;
    return r;
  endfunction

  task automatic queue_word(logic [1:0] kind, logic [7:0] addr, logic [31:0] data);
    cmd_word_t w;
    w.kind = kind;
    w.load_address = addr;
    w.load_data = data;
    w.console_value = $urandom;
    pending_words.insert(pending_words.size(), w);
    pending_results.insert(pending_results.size(), machine_step(w));
    words_queued++;
  endtask

  function automatic logic [31:0] encode(int idx, logic [7:0] addr);
    return {MNEMONICS[idx], 8'd0, addr};
  endfunction

  function automatic logic [31:0] random_instruction();
    if ($urandom_range(0, 24) == 0) return $urandom;
    return {MNEMONICS[$urandom_range(0, 24)], 16'($urandom)};
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Stimulus generation.
  initial begin
    int steps;
    rst = 1'b1;
    mach_a = '0;
    mach_b = '0;
    mach_pc = '0;
    mach_flag = FLAG_EQUAL;
    mach_run = 1'b0;
    words_queued = 0;
    error_count = 0;
    stimulus_done = 1'b0;

    // Step before any start, and an undefined kind.
    queue_word(KIND_STEP, 8'd0, '0);
    queue_word(2'd3, 8'hFF, 32'hFFFF_FFFF);
    // Every word is written before anything runs, so no read hits an unwritten word.
    for (int i = 0; i < 256; i++) queue_word(KIND_LOAD, i[7:0], random_instruction());

    // Operand extremes, and a program that divides, compares, branches and halts.
    queue_word(KIND_LOAD, 8'd250, 32'h8000_0000);
    queue_word(KIND_LOAD, 8'd251, 32'hFFFF_FFFF);
    queue_word(KIND_LOAD, 8'd252, 32'h0000_0000);
    queue_word(KIND_LOAD, 8'd253, 32'h7FFF_FFFF);
    queue_word(KIND_LOAD, 8'd0, encode(2, 8'd250));
    queue_word(KIND_LOAD, 8'd1, encode(3, 8'd251));
    queue_word(KIND_LOAD, 8'd2, encode(7, 8'd0));
    queue_word(KIND_LOAD, 8'd3, encode(8, 8'd0));
    queue_word(KIND_LOAD, 8'd4, encode(12, 8'd6));
    queue_word(KIND_LOAD, 8'd5, encode(15, 8'd0));
    queue_word(KIND_LOAD, 8'd6, encode(10, 8'd9));
    queue_word(KIND_LOAD, 8'd7, encode(11, 8'd9));
    queue_word(KIND_LOAD, 8'd8, encode(15, 8'd0));
    queue_word(KIND_LOAD, 8'd9, encode(3, 8'd253));
    queue_word(KIND_LOAD, 8'd10, encode(6, 8'd0));
    queue_word(KIND_LOAD, 8'd11, encode(4, 8'd0));
    queue_word(KIND_LOAD, 8'd12, encode(5, 8'd0));
    queue_word(KIND_LOAD, 8'd13, encode(13, 8'd249));
    queue_word(KIND_LOAD, 8'd14, encode(14, 8'd249));
    queue_word(KIND_LOAD, 8'd15, encode(0, 8'd248));
    queue_word(KIND_LOAD, 8'd16, encode(1, 8'd247));
    queue_word(KIND_LOAD, 8'd17, encode(16, 8'd0));
    queue_word(KIND_LOAD, 8'd18, encode(9, 8'd19));
    queue_word(KIND_LOAD, 8'd19, encode(15, 8'd0));
    queue_word(KIND_START, 8'd0, '0);
    repeat (21) queue_word(KIND_STEP, 8'd0, '0);
    // Divide by zero, then an unknown operation.
    queue_word(KIND_LOAD, 8'd0, encode(3, 8'd252));
    queue_word(KIND_LOAD, 8'd1, encode(7, 8'd0));
    queue_word(KIND_START, 8'd0, '0);
    repeat (3) queue_word(KIND_STEP, 8'd0, '0);
    queue_word(KIND_LOAD, 8'd0, 32'hFFFF_0000);
    queue_word(KIND_START, 8'd0, '0);
    repeat (2) queue_word(KIND_STEP, 8'd0, '0);

    // Random programs: a few loads, a start, then mostly steps.
    while (words_queued < TARGET_WORDS) begin
      repeat ($urandom_range(1, 12)) begin
        queue_word(KIND_LOAD, 8'($urandom),
                   ($urandom_range(0, 3) == 0) ? $urandom : random_instruction());
      end
      if ($urandom_range(0, 9) == 0) queue_word(2'd3, 8'($urandom), $urandom);
      queue_word(KIND_START, 8'($urandom), $urandom);
      steps = $urandom_range(4, 40);
      repeat (steps) begin
        case ($urandom_range(0, 19))
          0, 1: queue_word(KIND_LOAD, 8'($urandom), random_instruction());
          2: queue_word(2'd3, 8'($urandom), $urandom);
          default: queue_word(KIND_STEP, 8'($urandom), $urandom);
        endcase
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Command driver: bursts of words separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.data <= '0;
      burst_left <= $urandom_range(1, 20);
      gap_left <= 0;
      words_accepted <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        void'(pending_words.pop_front());
        expected_results.insert(expected_results.size(), pending_results.pop_front());
        words_accepted <= words_accepted + 1;
      end
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left > 0 || pending_words.size() == 0) begin
          cmd_ch.valid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          cmd_ch.valid <= 1'b1;
          cmd_ch.data <= pending_words[0];
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Result side: stall pattern that changes mode, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
      ready_mode <= 0;
      mode_left <= 64;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (!hold_done && words_accepted >= 400) begin
        hold_done <= 1'b1;
        hold_left <= 500;
        res_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        case (ready_mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 1) == 0);
          default: res_ch.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    res_word_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, res_ch.data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("status", 32'(want.status), 32'(res_ch.data.status));
        check_field("print_valid", 32'(want.print_valid), 32'(res_ch.data.print_valid));
        check_field("print_value", want.print_value, res_ch.data.print_value);
        check_field("next_counter", 32'(want.next_counter), 32'(res_ch.data.next_counter));
        check_field("reg_a_value", want.reg_a_value, res_ch.data.reg_a_value);
        check_field("reg_b_value", want.reg_b_value, res_ch.data.reg_b_value);
        check_field("compare_flag", 32'(want.compare_flag), 32'(res_ch.data.compare_flag));
        check_field("running_flag", 32'(want.running_flag), 32'(res_ch.data.running_flag));
      end
    end
  end

endmodule
